### src/fsc_pkg.sv
// fsc_pkg: shared types and constants for the frustum sphere cull block
// no dependencies
package fsc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int NUM_PLANES = 6;
	localparam int VAL_W = 32;
	localparam int COEF_W = 33;
	localparam int LEN_W = 34;
	localparam int SUM_W = 72;
	localparam int ISQ_STEPS = 36;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		coef_t x;
		coef_t y;
		coef_t z;
		coef_t w;
		len_t len;
	} plane_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] cx;
		logic signed [VAL_W-1:0] cy;
		logic signed [VAL_W-1:0] cz;
		logic signed [VAL_W-1:0] r;
	} sphere_t;

	typedef logic signed [SUM_W-1:0] sum_t;
endpackage

### src/fsc_cell.sv
// fsc_cell: one plane cell of the test chain, holds a plane and checks one sphere
// depends on fsc_pkg
module fsc_cell (
	input logic clk,
	input logic arst_n,
	input logic load,
	input fsc_pkg::plane_t plane_in,
	input logic valid_in,
	input fsc_pkg::sphere_t sphere_in,
	input logic pass_in,
	output logic valid_out,
	output fsc_pkg::sphere_t sphere_out,
	output logic pass_out
);
	import fsc_pkg::*;

	plane_t plane_q;
	logic valid_s1, pass_s1, valid_s2, pass_s2;
	sphere_t sphere_s1, sphere_s2;
	sum_t px_s1, py_s1, pz_s1, pw_s1, pr_s1;
	sum_t sum;

	always_comb sum = px_s1 + py_s1 + pz_s1 + pw_s1 + pr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load)
				plane_q <= plane_in;
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pass_s1 <= pass_in;
		sphere_s1 <= sphere_in;
		px_s1 <= SUM_W'(sphere_in.cx * plane_q.x);
		py_s1 <= SUM_W'(sphere_in.cy * plane_q.y);
		pz_s1 <= SUM_W'(sphere_in.cz * plane_q.z);
		pw_s1 <= SUM_W'(plane_q.w) <<< FRAC_BITS;
		pr_s1 <= SUM_W'(sphere_in.r * $signed({1'b0, plane_q.len}));
		sphere_s2 <= sphere_s1;
		pass_s2 <= pass_s1 && !(sum[SUM_W-1] || sum == '0);
	end

	assign valid_out = valid_s2;
	assign sphere_out = sphere_s2;
	assign pass_out = pass_s2;
endmodule

### src/fsc_plane_build.sv
// fsc_plane_build: rebuilds the six planes and their lengths after a row load
// depends on fsc_pkg; one plane at a time, bit-serial integer square root
module fsc_plane_build (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] row_index,
	input fsc_pkg::sphere_t row_vals,
	output logic busy,
	output logic [fsc_pkg::NUM_PLANES-1:0] load,
	output fsc_pkg::plane_t plane
);
	import fsc_pkg::*;

	typedef enum logic [1:0] {IDLE, SQR, ROOT, STORE} state_t;
	state_t state_q;
	logic signed [VAL_W-1:0] rows_q [16];
	logic [2:0] plane_q;
	logic [1:0] term_q;
	logic [5:0] bit_q;
	logic [SUM_W-1:0] acc_q;
	len_t root_q;
	coef_t cx, cy, cz, cw, csel;
	logic [COEF_W-1:0] m;
	logic [LEN_W-1:0] cand;
	logic [2*LEN_W-1:0] csq;

	function automatic coef_t comb(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic sub);
		coef_t ea, eb;
		ea = COEF_W'(a);
		eb = COEF_W'(b);
		return sub ? ea - eb : ea + eb;
	endfunction

	always_comb begin
		cx = comb(rows_q[12], rows_q[{plane_q[2:1], 2'd0}], plane_q[0]);
		cy = comb(rows_q[13], rows_q[{plane_q[2:1], 2'd1}], plane_q[0]);
		cz = comb(rows_q[14], rows_q[{plane_q[2:1], 2'd2}], plane_q[0]);
		cw = comb(rows_q[15], rows_q[{plane_q[2:1], 2'd3}], plane_q[0]);
		case (term_q)
			2'd0: csel = cx;
			2'd1: csel = cy;
			default: csel = cz;
		endcase
		m = csel[COEF_W-1] ? COEF_W'(-csel) : COEF_W'(csel);
		cand = root_q | (LEN_W'(1) << bit_q);
		csq = cand * cand;
		plane = '{x: cx, y: cy, z: cz, w: cw, len: root_q};
		load = '0;
		if (state_q == STORE)
			load[plane_q] = 1'b1;
	end

	assign busy = state_q != IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			for (int i = 0; i < 16; i++)
				rows_q[i] <= '0;
			plane_q <= '0;
			term_q <= '0;
			bit_q <= '0;
			acc_q <= '0;
			root_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: if (start) begin
					rows_q[{row_index, 2'd0}] <= row_vals.cx;
					rows_q[{row_index, 2'd1}] <= row_vals.cy;
					rows_q[{row_index, 2'd2}] <= row_vals.cz;
					rows_q[{row_index, 2'd3}] <= row_vals.r;
					plane_q <= '0;
					term_q <= '0;
					acc_q <= '0;
					state_q <= SQR;
				end
				SQR: begin
					acc_q <= acc_q + SUM_W'(m * m);
					term_q <= term_q + 2'd1;
					if (term_q == 2'd2) begin
						bit_q <= 6'(ISQ_STEPS - 1);
						root_q <= '0;
						state_q <= ROOT;
					end
				end
				ROOT: begin
					if (SUM_W'(csq) <= acc_q)
						root_q <= cand;
					bit_q <= bit_q - 6'd1;
					if (bit_q == '0)
						state_q <= STORE;
				end
				STORE: begin
					term_q <= '0;
					acc_q <= '0;
					if (plane_q == 3'(NUM_PLANES - 1)) begin
						state_q <= IDLE;
					end else begin
						plane_q <= plane_q + 3'd1;
						state_q <= SQR;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(load));
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ROOT |-> plane_q < 3'(NUM_PLANES)) else $error("plane index");
	assert property (@(posedge clk) disable iff (!arst_n)
		load != '0 |=> busy || $past(plane_q) == 3'(NUM_PLANES - 1)) else $error("store");
endmodule

### src/frustum_sphere_cull.sv
// frustum_sphere_cull: top level, plane builder plus a chain of six plane cells
// depends on fsc_pkg, fsc_plane_build, fsc_cell
//
// usage: s_axis carries items, tuser is op (0 load row, 1 test sphere),
// tdata packs row_index[1:0], val_a, val_b, val_c, val_d from bit 0 up.
// m_axis returns one in_view transaction per test item, loads answer nothing.
// a test item runs through six cells, each holding one plane and registering
// its products and then its pass flag, and then through the output register.
// only one test is in flight and a waiting result blocks the input, so the
// next item is taken only after the result has been accepted.
// a load rebuilds all six planes serially; per plane it sums the squares of
// x, y and z, takes the bit-serial square root and stores the plane in its
// cell. no new item is taken until the rebuild is done.
// reset clears the matrix, planes and control; a stalled receiver holds the
// result and blocks new input until it is taken.
module frustum_sphere_cull (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [135:0] s_axis_tdata, // row_index, val_a, val_b, val_c, val_d, pad
	input logic [0:0] s_axis_tuser, // op
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata // in_view, pad
);
	import fsc_pkg::*;

	logic busy, inflight_q, out_v_q, out_d_q, acc;
	logic [NUM_PLANES-1:0] load;
	plane_t plane;
	sphere_t vals;
	logic v [NUM_PLANES+1];
	logic p [NUM_PLANES+1];
	sphere_t s [NUM_PLANES+1];

	assign vals = '{cx: s_axis_tdata[33:2], cy: s_axis_tdata[65:34],
		cz: s_axis_tdata[97:66], r: s_axis_tdata[129:98]};
	assign s_axis_tready = !busy && !inflight_q && !out_v_q;
	assign acc = s_axis_tvalid && s_axis_tready;

	fsc_plane_build u_build (.clk, .arst_n, .start(acc && s_axis_tuser[0] == OP_LOAD),
		.row_index(s_axis_tdata[1:0]), .row_vals(vals), .busy, .load, .plane);

	assign v[0] = acc && s_axis_tuser[0] == OP_TEST;
	assign p[0] = 1'b1;
	assign s[0] = vals;

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		fsc_cell u_cell (.clk, .arst_n, .load(load[i]), .plane_in(plane),
			.valid_in(v[i]), .sphere_in(s[i]), .pass_in(p[i]),
			.valid_out(v[i+1]), .sphere_out(s[i+1]), .pass_out(p[i+1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 1'b0;
			out_v_q <= 1'b0;
			out_d_q <= 1'b0;
		end else begin
			if (v[0])
				inflight_q <= 1'b1;
			else if (v[NUM_PLANES])
				inflight_q <= 1'b0;
			if (v[NUM_PLANES]) begin
				out_v_q <= 1'b1;
				out_d_q <= p[NUM_PLANES];
			end else if (m_axis_tready)
				out_v_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {7'd0, out_d_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		v[NUM_PLANES] |-> !out_v_q) else $error("result overwrite");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !busy) else $error("accept while building");
	assert property (@(posedge clk) disable iff (!arst_n)
		v[NUM_PLANES] |-> inflight_q) else $error("spurious result");
endmodule
